// ===== rtl/pfe_pkg.sv =====
// Types, letter constants and key-square geometry tables for the
// Playfair digraph encryptor. No dependencies.
`default_nettype none

package pfe_pkg;

  localparam int unsigned LetterW  = 5;
  localparam int unsigned Side     = 5;
  localparam int unsigned Cells    = Side * Side;
  localparam int unsigned CellIdxW = $clog2(Cells);
  localparam int unsigned RcW      = $clog2(Side);
  localparam int unsigned CfgDataW = 60;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CellsPerReg = CfgDataW / LetterW;
  localparam int unsigned PairDepth   = 4;

  localparam logic [LetterW-1:0] LetterI = LetterW'(8);
  localparam logic [LetterW-1:0] LetterJ = LetterW'(9);
  localparam logic [LetterW-1:0] LetterX = LetterW'(23);

  typedef enum logic [CfgIdxW-1:0] {
    CfgCellsLow = 2'd0,
    CfgCellsMid = 2'd1,
    CfgCellLast = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic               end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [LetterW-1:0] cipher_letter;
    logic               final_letter;
  } out_item_t;

  typedef struct packed {
    logic [LetterW-1:0] first;
    logic [LetterW-1:0] second;
    logic               last;
  } digraph_t;

  // Row and column of each cell index.
  localparam logic [RcW-1:0] RowOf [Cells] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };
  localparam logic [RcW-1:0] ColOf [Cells] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4
  };

  function automatic logic [LetterW-1:0] fold_j(input logic [LetterW-1:0] c);
    return (c == LetterJ) ? LetterI : c;
  endfunction

  function automatic logic [RcW-1:0] wrap_inc(input logic [RcW-1:0] v);
    return (v == RcW'(Side - 1)) ? '0 : RcW'(v + 1'b1);
  endfunction

  function automatic logic [CellIdxW-1:0] cell_index(input logic [RcW-1:0] r,
                                                     input logic [RcW-1:0] k);
    return CellIdxW'(r * Side + k);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/playfair_digraph_encrypt_core.sv =====
// Playfair digraph encryptor top level: pairing front end, digraph queue,
// key-square lookup and cipher letter output. Depends on pfe_pkg.
`default_nettype none

// Plaintext letters (0-25, j folded to i) enter on the in channel, at most one
// per cycle, and are paired into digraphs with x inserted between a doubled
// letter and x padding an odd final letter. Digraphs wait in a four-entry
// queue; the input is ready while the queue has room for two. Each digraph is
// looked up in the 5x5 key square written over the config port and leaves as
// two cipher letters, one per cycle while out_ready_i is high, so the output
// port sets the rate. A digraph passes through the digraph queue and then the
// result register before its first cipher letter is output. Write the
// square only while the block is idle.
module playfair_digraph_encrypt_core (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire [pfe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire [pfe_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire pfe_pkg::in_item_t    in_data_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output pfe_pkg::out_item_t        out_data_o
);

  localparam int unsigned PtrW = $clog2(pfe_pkg::PairDepth);
  localparam int unsigned CntW = $clog2(pfe_pkg::PairDepth + 1);
  localparam int unsigned LW   = pfe_pkg::LetterW;
  localparam int unsigned NC   = pfe_pkg::Cells;
  localparam int unsigned CPR  = pfe_pkg::CellsPerReg;

  // Key square registers.
  logic [pfe_pkg::CfgDataW-1:0] cells_low_q, cells_mid_q;
  logic [LW-1:0]                cell_last_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_low_q <= '0;
      cells_mid_q <= '0;
      cell_last_q <= '0;
    end else if (cfg_valid_i) begin
      case (pfe_pkg::cfg_reg_e'(cfg_index_i))
        pfe_pkg::CfgCellsLow: cells_low_q <= cfg_data_i;
        pfe_pkg::CfgCellsMid: cells_mid_q <= cfg_data_i;
        pfe_pkg::CfgCellLast: cell_last_q <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  logic [LW-1:0] cells [NC];
  always_comb begin
    for (int n = 0; n < NC; n++) begin
      if (n < CPR) begin
        cells[n] = cells_low_q[n*LW +: LW];
      end else if (n < 2 * CPR) begin
        cells[n] = cells_mid_q[(n-CPR)*LW +: LW];
      end else begin
        cells[n] = cell_last_q;
      end
    end
  end

  // Pairing front end.
  logic          pend_valid_q, pend_valid_d;
  logic [LW-1:0] pend_letter_q, pend_letter_d;
  logic [LW-1:0] in_letter;
  logic          in_fire;
  logic [1:0]    push_n;
  pfe_pkg::digraph_t push0, push1;

  assign in_letter = pfe_pkg::fold_j(in_data_i.letter);
  assign in_fire   = in_valid_i && in_ready_o;

  always_comb begin
    pend_valid_d  = pend_valid_q;
    pend_letter_d = pend_letter_q;
    push_n        = 2'd0;
    push0         = '{first: pend_letter_q, second: in_letter,
                      last: in_data_i.end_of_message};
    push1         = '{first: in_letter, second: pfe_pkg::LetterX, last: 1'b1};
    if (in_fire) begin
      if (!pend_valid_q) begin
        if (in_data_i.end_of_message) begin
          push0  = '{first: in_letter, second: pfe_pkg::LetterX, last: 1'b1};
          push_n = 2'd1;
        end else begin
          pend_valid_d  = 1'b1;
          pend_letter_d = in_letter;
        end
      end else if (pend_letter_q != in_letter) begin
        push_n        = 2'd1;
        pend_valid_d  = 1'b0;
        pend_letter_d = '0;
      end else begin
        push0 = '{first: pend_letter_q, second: pfe_pkg::LetterX, last: 1'b0};
        if (in_data_i.end_of_message) begin
          push_n        = 2'd2;
          pend_valid_d  = 1'b0;
          pend_letter_d = '0;
        end else begin
          push_n = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q  <= 1'b0;
      pend_letter_q <= '0;
    end else begin
      pend_valid_q  <= pend_valid_d;
      pend_letter_q <= pend_letter_d;
    end
  end

  // Digraph queue.
  pfe_pkg::digraph_t queue_q [pfe_pkg::PairDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              pop;
  pfe_pkg::digraph_t head;

  assign in_ready_o = (count_q <= CntW'(pfe_pkg::PairDepth - 2));
  assign head       = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= push0;
    end
    if (push_n == 2'd2) begin
      queue_q[PtrW'(wr_ptr_q + 1'b1)] <= push1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= PtrW'(wr_ptr_q + push_n);
      rd_ptr_q <= PtrW'(rd_ptr_q + pop);
      count_q  <= CntW'(count_q + push_n - pop);
    end
  end

  // Key-square lookup: lowest matching cell wins, no match means cell 0.
  logic [pfe_pkg::CellIdxW-1:0] pos1, pos2, idx1, idx2;
  logic [pfe_pkg::RcW-1:0]      r1, k1, r2, k2;

  always_comb begin
    pos1 = '0;
    pos2 = '0;
    for (int n = NC - 1; n >= 0; n--) begin
      if (pfe_pkg::fold_j(cells[n]) == head.first) begin
        pos1 = pfe_pkg::CellIdxW'(n);
      end
      if (pfe_pkg::fold_j(cells[n]) == head.second) begin
        pos2 = pfe_pkg::CellIdxW'(n);
      end
    end
    r1 = pfe_pkg::RowOf[pos1];
    k1 = pfe_pkg::ColOf[pos1];
    r2 = pfe_pkg::RowOf[pos2];
    k2 = pfe_pkg::ColOf[pos2];
    if (r1 == r2) begin
      idx1 = pfe_pkg::cell_index(r1, pfe_pkg::wrap_inc(k1));
      idx2 = pfe_pkg::cell_index(r2, pfe_pkg::wrap_inc(k2));
    end else if (k1 == k2) begin
      idx1 = pfe_pkg::cell_index(pfe_pkg::wrap_inc(r1), k1);
      idx2 = pfe_pkg::cell_index(pfe_pkg::wrap_inc(r2), k2);
    end else begin
      idx1 = pfe_pkg::cell_index(r1, k2);
      idx2 = pfe_pkg::cell_index(r2, k1);
    end
  end

  // Result register: one encrypted digraph, drained one letter per cycle while out_ready_i is high.
  logic [LW-1:0] res_c1_q, res_c2_q;
  logic          res_last_q;
  logic [1:0]    res_cnt_q;

  assign pop = (count_q != '0) &&
               ((res_cnt_q == 2'd0) || ((res_cnt_q == 2'd1) && out_ready_i));

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_c1_q   <= cells[idx1];
      res_c2_q   <= cells[idx2];
      res_last_q <= head.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= 2'd0;
    end else if (pop) begin
      res_cnt_q <= 2'd2;
    end else if (out_valid_o && out_ready_i) begin
      res_cnt_q <= 2'(res_cnt_q - 1'b1);
    end
  end

  assign out_valid_o = (res_cnt_q != 2'd0);
  assign out_data_o  = '{cipher_letter: (res_cnt_q == 2'd2) ? res_c1_q : res_c2_q,
                         final_letter:  (res_cnt_q == 2'd1) && res_last_q};

endmodule

`default_nettype wire
